// ===== hw/rtl/qmr_pkg.sv =====
// qmr_pkg: shared types and constants for the quaternion multiply / rotate pipeline
// no dependencies; imported by qmr_ham and quaternion_multiply_rotate
package qmr_pkg;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [32:0] fxw_t;
  typedef logic [1:0]         comp_idx_t;

  localparam logic OP_PRODUCT = 1'b0;
  localparam logic OP_ROTATE  = 1'b1;

  // component order x, y, z, w; term t of component c is a[HA_IDX] * b[HB_IDX]
  localparam comp_idx_t HA_IDX [4][4] = '{
    '{2'd3, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd1, 2'd2, 2'd0},
    '{2'd3, 2'd2, 2'd0, 2'd1},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  localparam comp_idx_t HB_IDX [4][4] = '{
    '{2'd0, 2'd3, 2'd2, 2'd1},
    '{2'd1, 2'd3, 2'd0, 2'd2},
    '{2'd2, 2'd3, 2'd1, 2'd0},
    '{2'd3, 2'd0, 2'd1, 2'd2}
  };
  // bit t set: term t is subtracted
  localparam logic [3:0] HNEG [4] = '{4'b1000, 4'b1000, 4'b1000, 4'b1110};

  typedef struct packed {
    logic           op;
    logic           sat;
    fx_t [3:0]      q;
  } qmr_side_t;

endpackage

// ===== hw/rtl/qmr_ham.sv =====
// qmr_ham: three-stage pipelined Hamilton product with per-term rounding and per-component saturation
// depends on qmr_pkg
module qmr_ham #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  qmr_pkg::fx_t  [3:0]  a,
  input  qmr_pkg::fxw_t [3:0]  b,
  input  qmr_pkg::qmr_side_t   side_in,
  output logic                 out_valid,
  output qmr_pkg::fx_t  [3:0]  res,
  output logic          [3:0]  clip,
  output qmr_pkg::qmr_side_t   side_out
);
  import qmr_pkg::*;

  localparam int PW = 65;
  localparam int SW = 67;
  localparam logic signed [PW-1:0] RBIAS = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SMAX  = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] SMIN  = {{(SW-31){1'b1}}, {31{1'b0}}};

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  logic        v1_r, v2_r, v3_r;
  qmr_side_t   side1_r, side2_r, side3_r;
  prod_t       prod_nxt [16];
  prod_t       prod_r   [16];
  prod_t       rnd_nxt  [16];
  prod_t       rnd_r    [16];
  fx_t  [3:0]  res_nxt, res_r;
  logic [3:0]  clip_nxt, clip_r;
  sum_t        acc;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        prod_nxt[c*4+t] = PW'($signed(a[HA_IDX[c][t]])) * PW'($signed(b[HB_IDX[c][t]]));
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      rnd_nxt[k] = (prod_r[k] + RBIAS) >>> FRAC_BITS;
    end
  end

  always_comb begin
    acc = '0;
    for (int c = 0; c < 4; c++) begin
      acc = SW'(rnd_r[c*4]);
      for (int t = 1; t < 4; t++) begin
        if (HNEG[c][t]) begin
          acc = acc - SW'(rnd_r[c*4+t]);
        end else begin
          acc = acc + SW'(rnd_r[c*4+t]);
        end
      end
      if (acc > SMAX) begin
        res_nxt[c]  = SMAX[31:0];
        clip_nxt[c] = 1'b1;
      end else if (acc < SMIN) begin
        res_nxt[c]  = SMIN[31:0];
        clip_nxt[c] = 1'b1;
      end else begin
        res_nxt[c]  = acc[31:0];
        clip_nxt[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    side1_r <= side_in;
    rnd_r   <= rnd_nxt;
    side2_r <= side1_r;
    res_r   <= res_nxt;
    clip_r  <= clip_nxt;
    side3_r <= side2_r;
  end

  assign out_valid = v3_r;
  assign res       = res_r;
  assign clip      = clip_r;
  assign side_out  = side3_r;

endmodule

// ===== hw/rtl/quaternion_multiply_rotate.sv =====
// quaternion_multiply_rotate: Hamilton product or vector rotation q * v * conj(q), Q16.16
// depends on qmr_pkg and qmr_ham (two passes in series)
//
//   channel   handshake          payload
//   in        start / busy       in_operation, in_qa_*, in_qb_*
//   out       out_valid strobe   out_res_x/y/z/w, out_saturated
//
// one beat accepted per cycle; busy stays low since nothing can stall
// pipeline: multiply, round, sum and clip stages in each Hamilton pass, then the output register
// the product mode also runs through the second pass, unused, to keep results in order
// rst_n clears the valid bits only; payload registers are not reset
module quaternion_multiply_rotate #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic signed [31:0]  in_qa_x,
  input  logic signed [31:0]  in_qa_y,
  input  logic signed [31:0]  in_qa_z,
  input  logic signed [31:0]  in_qa_w,
  input  logic signed [31:0]  in_qb_x,
  input  logic signed [31:0]  in_qb_y,
  input  logic signed [31:0]  in_qb_z,
  input  logic signed [31:0]  in_qb_w,
  output logic                out_valid,
  output logic signed [31:0]  out_res_x,
  output logic signed [31:0]  out_res_y,
  output logic signed [31:0]  out_res_z,
  output logic signed [31:0]  out_res_w,
  output logic                out_saturated
);
  import qmr_pkg::*;

  logic        accept;
  fx_t  [3:0]  a1, a2, res1, res2;
  fxw_t [3:0]  b1, b2;
  qmr_side_t   side1, side1_o, side2, side2_o;
  logic [3:0]  clip1, clip2;
  logic        p1_valid, p2_valid;

  logic        out_valid_r;
  logic        fin_op_r;
  fx_t  [3:0]  fin_nxt, fin_r;
  logic        sat_nxt, sat_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    a1[0] = in_qa_x;
    a1[1] = in_qa_y;
    a1[2] = in_qa_z;
    a1[3] = in_qa_w;
    b1[0] = 33'(in_qb_x);
    b1[1] = 33'(in_qb_y);
    b1[2] = 33'(in_qb_z);
    b1[3] = (in_operation == OP_ROTATE) ? '0 : 33'(in_qb_w);
    side1.op  = in_operation;
    side1.sat = 1'b0;
    side1.q   = a1;
  end

  qmr_ham #(.FRAC_BITS(FRAC_BITS)) u_pass1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .a        (a1),
    .b        (b1),
    .side_in  (side1),
    .out_valid(p1_valid),
    .res      (res1),
    .clip     (clip1),
    .side_out (side1_o)
  );

  // second operand is the conjugate of qa, negated exactly in 33 bits
  always_comb begin
    a2 = res1;
    for (int i = 0; i < 3; i++) begin
      b2[i] = -33'($signed(side1_o.q[i]));
    end
    b2[3]     = 33'($signed(side1_o.q[3]));
    side2.op  = side1_o.op;
    side2.sat = |clip1;
    side2.q   = res1;
  end

  qmr_ham #(.FRAC_BITS(FRAC_BITS)) u_pass2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (p1_valid),
    .a        (a2),
    .b        (b2),
    .side_in  (side2),
    .out_valid(p2_valid),
    .res      (res2),
    .clip     (clip2),
    .side_out (side2_o)
  );

  always_comb begin
    if (side2_o.op == OP_ROTATE) begin
      fin_nxt[2:0] = res2[2:0];
      fin_nxt[3]   = '0;
      sat_nxt      = side2_o.sat | (|clip2[2:0]);
    end else begin
      fin_nxt = side2_o.q;
      sat_nxt = side2_o.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    fin_r    <= fin_nxt;
    sat_r    <= sat_nxt;
    fin_op_r <= side2_o.op;
  end

  assign out_valid     = out_valid_r;
  assign out_res_x     = fin_r[0];
  assign out_res_y     = fin_r[1];
  assign out_res_z     = fin_r[2];
  assign out_res_w     = fin_r[3];
  assign out_saturated = sat_r;

`ifndef SYNTH
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_valid)
    else $error("accepted beat did not come out after 7 cycles");

  a_pass_order : assert property (@(posedge clk) disable iff (!rst_n)
    p2_valid |-> $past(p1_valid, 3))
    else $error("second pass valid without first pass valid");

  a_rotate_w : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && fin_op_r == OP_ROTATE) |-> (out_res_w == '0))
    else $error("rotate result has nonzero w");
`endif

endmodule
